@@ src/svt_pkg.sv @@
// Shared types and constants for the sortable value table.
// Holds table geometry, operation and status codes, and the controller/datapath structs.
// No dependencies.
package svt_pkg;

   localparam int DEPTH = 16;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // operation codes carried in the op field
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_DISPLAY = 3'd1;
   localparam logic [2:0] OP_DELETE  = 3'd2;
   localparam logic [2:0] OP_UPDATE  = 3'd3;
   localparam logic [2:0] OP_SEARCH  = 3'd4;
   localparam logic [2:0] OP_SORT    = 3'd5;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // what the datapath does with the read data in the cycle after a read
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_SWAP,
      ACT_MATCH,
      ACT_EMIT
   } action_type;

   typedef enum logic [1:0] {
      WSEL_VALUE,
      WSEL_ZERO,
      WSEL_CUR
   } wsel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SORT_LOAD,
      S_SORT_SCAN,
      S_SORT_DRAIN,
      S_SORT_WB,
      S_SEARCH_SCAN,
      S_SEARCH_DRAIN,
      S_DISP_RD,
      S_DISP_EMIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic            req_load;
      logic            rd_en;
      logic [AW-1:0]   rd_addr;
      action_type      act;
      logic            wr_en;
      logic [AW-1:0]   wr_addr;
      wsel_type        wr_sel;
      logic            fill_inc;
      logic            search_clr;
      logic            out_load;
      status_type      out_status;
      logic            out_use_found;
   } cmd_type;

   typedef struct packed {
      logic [2:0]      op;
      logic            pos_ok;
      logic [AW-1:0]   pos_addr;
      logic            full;
      logic [AW-1:0]   fill_addr;
      logic            out_free;
   } stat_type;

endpackage

@@ src/svt_ifs.sv @@
// Request and response channel interfaces for the sortable value table.
// Depends on svt_pkg for nothing but keeps the same house import style.
interface svt_req_if;
   import svt_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [7:0]         position;
   logic signed [31:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface svt_rsp_if;
   import svt_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [3:0]         found_index;
   logic signed [31:0] entry_value;
   logic               last;

   modport source (output valid, output status, output found_index, output entry_value,
                   output last, input ready);
   modport sink   (input valid, input status, input found_index, input entry_value,
                   input last, output ready);
endinterface

@@ src/svt_dp.sv @@
// Datapath of the sortable value table: request registers, entry memory with
// registered reads, compare/swap stage, search match, fill pointer and output register.
// Depends on svt_pkg.
module svt_dp (
   input  logic               clock,
   input  logic               reset,
   input  svt_pkg::cmd_type   cmd,
   output svt_pkg::stat_type  stat,
   input  logic [2:0]         req_op,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_found_index,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);
   import svt_pkg::*;

   logic [2:0]         op_ff;
   logic [7:0]         pos_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      fill_ff;

   logic signed [31:0] mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic signed [31:0] rdata_ff;

   action_type         act_ff;
   logic [AW-1:0]      act_addr_ff;
   logic signed [31:0] cur_ff, cur_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      found_idx_ff, found_idx_in;

   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [3:0]         out_idx_ff, out_idx_in;
   logic signed [31:0] out_entry_ff, out_entry_in;
   logic               out_last_ff, out_last_in;

   logic               swap_wr;
   logic               wr_en_c;
   logic [AW-1:0]      wr_addr_c;
   logic signed [31:0] wr_data_c;

   // latch the transaction payload
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff    <= req_op;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
   end

   // advance the fill pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.fill_inc) begin
         fill_ff <= fill_ff + CW'(1);
      end
   end

   // merge the sequencer write and the swap write onto one port
   always_comb begin
      swap_wr   = (act_ff == ACT_SWAP) && (cur_ff > rdata_ff);
      wr_en_c   = cmd.wr_en || swap_wr;
      wr_addr_c = swap_wr ? act_addr_ff : cmd.wr_addr;
      if (swap_wr) begin
         wr_data_c = cur_ff;
      end else begin
         case (cmd.wr_sel)
            WSEL_VALUE: wr_data_c = value_ff;
            WSEL_ZERO:  wr_data_c = '0;
            WSEL_CUR:   wr_data_c = cur_ff;
            default:    wr_data_c = '0;
         endcase
      end
   end

   // entry memory, read data registered
   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         mem[wr_addr_c] <= wr_data_c;
      end
      if (cmd.rd_en) begin
         rdata_ff <= vld_ff[cmd.rd_addr] ? mem[cmd.rd_addr] : '0;
      end
   end

   // mark written entries; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en_c) begin
         vld_ff[wr_addr_c] <= 1'b1;
      end
   end

   // track the action that goes with each read
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_NONE;
      end else begin
         act_ff <= cmd.rd_en ? cmd.act : ACT_NONE;
      end
      act_addr_ff <= cmd.rd_addr;
   end

   // hold the running minimum and the search result
   always_comb begin
      cur_in       = cur_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      if (act_ff == ACT_LOAD || swap_wr) begin
         cur_in = rdata_ff;
      end
      if (cmd.search_clr) begin
         found_in     = 1'b0;
         found_idx_in = '0;
      end else if (act_ff == ACT_MATCH && !found_ff && rdata_ff == value_ff) begin
         found_in     = 1'b1;
         found_idx_in = act_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
   end

   // load the output register on a single result or a display entry
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_idx_in    = out_idx_ff;
      out_entry_in  = out_entry_ff;
      out_last_in   = out_last_ff;
      if (act_ff == ACT_EMIT) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_idx_in    = '0;
         out_entry_in  = rdata_ff;
         out_last_in   = (act_addr_ff == LAST_ADDR);
      end else if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_entry_in  = '0;
         out_last_in   = 1'b1;
         if (cmd.out_use_found) begin
            out_status_in = found_ff ? ST_OK : ST_NOTFOUND;
            out_idx_in    = found_ff ? 4'(found_idx_ff) : 4'd0;
         end else begin
            out_status_in = cmd.out_status;
            out_idx_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_status_ff <= out_status_in;
      out_idx_ff    <= out_idx_in;
      out_entry_ff  <= out_entry_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_index = out_idx_ff;
   assign rsp_entry_value = out_entry_ff;
   assign rsp_last        = out_last_ff;

   // status toward the controller
   always_comb begin
      stat.op        = op_ff;
      stat.pos_ok    = pos_ff < 8'(DEPTH);
      stat.pos_addr  = pos_ff[AW-1:0];
      stat.full      = (fill_ff == CW'(DEPTH));
      stat.fill_addr = fill_ff[AW-1:0];
      stat.out_free  = !out_valid_ff || rsp_ready;
   end

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      swap_wr |-> !cmd.wr_en)
      else $error("sequencer write collides with swap write");

   a_no_rw_same_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en_c && cmd.rd_en) |-> (wr_addr_c != cmd.rd_addr))
      else $error("read and write at the same entry in one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill pointer beyond table depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (act_ff == ACT_EMIT || cmd.out_load) |-> (!out_valid_ff || rsp_ready))
      else $error("output register loaded over a pending result");

endmodule

@@ src/svt_ctrl.sv @@
// Controller of the sortable value table: decodes each operation and sequences
// reads, writes and result loads for the datapath.
// Depends on svt_pkg.
module svt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  svt_pkg::stat_type  stat,
   output svt_pkg::cmd_type   cmd
);
   import svt_pkg::*;

   state_type     state_ff, state_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   status_type    st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      st_ff <= st_in;
   end

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      st_in     = st_ff;
      req_ready = 1'b0;
      cmd       = '0;

      case (state_ff)
         // hold off requests while reset is asserted
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end

         S_DECODE: begin
            st_in    = ST_OK;
            state_in = S_RESP;
            case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     st_in = ST_FULL;
                  end else begin
                     cmd.wr_en    = 1'b1;
                     cmd.wr_addr  = stat.fill_addr;
                     cmd.wr_sel   = WSEL_VALUE;
                     cmd.fill_inc = 1'b1;
                  end
               end
               OP_DISPLAY: begin
                  j_in     = '0;
                  state_in = S_DISP_RD;
               end
               OP_DELETE, OP_UPDATE: begin
                  if (!stat.pos_ok) begin
                     st_in = ST_BADPOS;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = stat.pos_addr;
                     cmd.wr_sel  = (stat.op == OP_DELETE) ? WSEL_ZERO : WSEL_VALUE;
                  end
               end
               OP_SEARCH: begin
                  cmd.search_clr = 1'b1;
                  j_in           = '0;
                  state_in       = S_SEARCH_SCAN;
               end
               OP_SORT: begin
                  i_in     = '0;
                  state_in = S_SORT_LOAD;
               end
               default: begin
                  st_in = ST_OK;
               end
            endcase
         end

         // load entry i as the running minimum
         S_SORT_LOAD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff;
            cmd.act     = ACT_LOAD;
            j_in        = i_ff + AW'(1);
            state_in    = S_SORT_SCAN;
         end

         // compare and exchange entry j against the running minimum
         S_SORT_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff;
            cmd.act     = ACT_SWAP;
            if (j_ff == LAST_ADDR) begin
               state_in = S_SORT_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end

         S_SORT_DRAIN: begin
            state_in = S_SORT_WB;
         end

         // write back entry i and start the next pass, or go to the response after the last pass
         S_SORT_WB: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_sel  = WSEL_CUR;
            if (i_ff == LAST_ADDR - AW'(1)) begin
               st_in    = ST_OK;
               state_in = S_RESP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_ff + AW'(1);
               cmd.act     = ACT_LOAD;
               i_in        = i_ff + AW'(1);
               j_in        = i_ff + AW'(2);
               state_in    = S_SORT_SCAN;
            end
         end

         S_SEARCH_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff;
            cmd.act     = ACT_MATCH;
            if (j_ff == LAST_ADDR) begin
               state_in = S_SEARCH_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end

         S_SEARCH_DRAIN: begin
            state_in = S_RESP;
         end

         // read one entry once the output register can take it
         S_DISP_RD: begin
            if (stat.out_free) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff;
               cmd.act     = ACT_EMIT;
               state_in    = S_DISP_EMIT;
            end
         end

         S_DISP_EMIT: begin
            if (j_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = S_DISP_RD;
            end
         end

         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_status    = st_ff;
               cmd.out_use_found = (stat.op == OP_SEARCH);
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/sortable_value_table.sv @@
// Sortable value table: DEPTH signed entries, one operation per request transaction.
// Insert/delete/update/unused ops answer after decode; search after scanning every entry.
// Sort: a pass for each entry but the last, one entry pair per cycle within each scan.
// Display: each entry is read once the output register is free; a stalled response
// holds the sequence. The next request is accepted the cycle after the last result loads.
// Synchronous reset clears the fill pointer and entry valid bits; entries read as zero.
module sortable_value_table (
   input  logic      clock,
   input  logic      reset,
   svt_req_if.sink   req_ch,
   svt_rsp_if.source rsp_ch
);
   import svt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ready_c;

   svt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready_c),
      .stat      (stat),
      .cmd       (cmd)
   );

   svt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_ch.op),
      .req_position    (req_ch.position),
      .req_value       (req_ch.value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_found_index (rsp_ch.found_index),
      .rsp_entry_value (rsp_ch.entry_value),
      .rsp_last        (rsp_ch.last)
   );

   assign req_ch.ready = ready_c;

endmodule
